@@ rtl/ttb_pkg.sv @@
// shared types and codes for the tick timer bank
`timescale 1ns / 1ps
`default_nettype none

package ttb_pkg;

    // operation codes
    localparam logic [2:0] OP_TICK   = 3'd0;
    localparam logic [2:0] OP_ASSIGN = 3'd1;
    localparam logic [2:0] OP_KICK   = 3'd2;
    localparam logic [2:0] OP_STOP   = 3'd3;
    localparam logic [2:0] OP_KILL   = 3'd4;

    // result kinds
    localparam logic [1:0] KIND_DONE     = 2'd0;
    localparam logic [1:0] KIND_ASSIGNED = 2'd1;
    localparam logic [1:0] KIND_EXPIRED  = 2'd2;
    localparam logic [1:0] KIND_ERROR    = 2'd3;

    // error codes
    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_NOT_IN_USE = 2'd1;
    localparam logic [1:0] ERR_NO_FREE    = 2'd2;

    // field widths fixed by the interface
    localparam int OPCODE_W = 3;
    localparam int INDEX_W  = 4;
    localparam int LOAD_W   = 16;

    // expiries reported per tick and the counter that caps them
    localparam int MAX_RESULTS = 16;
    localparam int CNT_W       = 5;

    // width used to compare a timer index against a cell position
    localparam int ID_W = 7;

    // direct command broadcast to every cell in the transfer cycle
    typedef struct packed {
        logic                valid;
        logic [OPCODE_W-1:0] opcode;
        logic [INDEX_W-1:0]  timer_index;
        logic [LOAD_W-1:0]   load_value;
    } ttb_cmd_t;

    // what the token running down the chain is doing
    typedef struct packed {
        logic assign_op;
        logic periodic;
    } ttb_scan_t;

endpackage

`default_nettype wire

@@ rtl/ttb_cell.sv @@
// one timer cell: state of a single timer plus its token stage
`timescale 1ns / 1ps
`default_nettype none

module ttb_cell #(
    parameter int INDEX     = 0,
    parameter int TICK_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  ttb_pkg::ttb_cmd_t cmd,
    input  ttb_pkg::ttb_scan_t scan,
    input  logic              tok_in,
    output logic              tok_out,
    output logic              hit,
    output logic              sel
);
    import ttb_pkg::*;

    localparam logic [ID_W-1:0] MY_ID = ID_W'(INDEX);

    logic                 in_use_reg, in_use_next;
    logic                 periodic_reg, periodic_next;
    logic [TICK_BITS-1:0] remaining_reg, remaining_next;
    logic [TICK_BITS-1:0] reload_reg, reload_next;
    logic                 tok_reg;

    logic                 match;
    logic                 direct;
    logic                 tick_act;
    logic                 expire;
    logic                 claim;
    logic [TICK_BITS-1:0] rem_dec;

    assign match  = (ID_W'(cmd.timer_index) == MY_ID);
    assign direct = cmd.valid && ((cmd.opcode == OP_KICK) || (cmd.opcode == OP_STOP)
                                  || (cmd.opcode == OP_KILL));
    assign sel    = direct && match && in_use_reg;

    assign tick_act = tok_reg && !scan.assign_op && in_use_reg && (remaining_reg != '0);
    assign rem_dec  = remaining_reg - TICK_BITS'(1);
    assign expire   = tick_act && (rem_dec == '0);
    assign claim    = tok_reg && scan.assign_op && !in_use_reg;

    assign hit     = expire || claim;
    // an assign token stops at the cell that claims it
    assign tok_out = tok_reg && !claim;

    always_comb
    begin
        in_use_next    = in_use_reg;
        periodic_next  = periodic_reg;
        remaining_next = remaining_reg;
        reload_next    = reload_reg;
        if (sel)
        begin
            priority if (cmd.opcode == OP_KILL)
            begin
                in_use_next = 1'b0;
            end
            else if (cmd.opcode == OP_KICK)
            begin
                remaining_next = TICK_BITS'(cmd.load_value);
                reload_next    = TICK_BITS'(cmd.load_value);
            end
            else
            begin
                remaining_next = '0;
                reload_next    = '0;
            end
        end
        else if (claim)
        begin
            in_use_next    = 1'b1;
            periodic_next  = scan.periodic;
            remaining_next = '0;
            reload_next    = '0;
        end
        else if (tick_act)
        begin
            if (expire)
            begin
                remaining_next = periodic_reg ? reload_reg : '0;
            end
            else
            begin
                remaining_next = rem_dec;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_use_reg    <= 1'b0;
            remaining_reg <= '0;
            tok_reg       <= 1'b0;
        end
        else
        begin
            in_use_reg    <= in_use_next;
            remaining_reg <= remaining_next;
            tok_reg       <= tok_in;
        end
    end

    // mode and reload are written by assign before they are ever read
    always_ff @(posedge clk)
    begin
        periodic_reg <= periodic_next;
        reload_reg   <= reload_next;
    end

endmodule

`default_nettype wire

@@ rtl/tick_timer_bank_unit.sv @@
// top level of the tick timer bank: cell chain, scan sequencer, result register
`timescale 1ns / 1ps
`default_nettype none

// A bank of NUM_TIMERS countdown timers, one per cell in a chain. A command is
// transferred when start is high and busy is low. Kick, stop and kill act on
// the addressed cell in the transfer cycle, unused opcodes on no cell; each
// gives one result in the next cycle; busy stays low, so a new command may
// follow at once. Tick and assign send a token down the chain, one cell per
// cycle: a tick keeps busy high until the token has passed every cell and the
// final expiry is flushed, an assign until the token reaches the first free cell
// or the last cell. Results come one per cycle on result_valid and must be taken
// when shown; the receiver cannot stall the bank. Expiries of one tick arrive
// in index order, each held back one slot so that the final one can carry
// last; only the first sixteen expiries of a tick are reported and
// result_index holds the low four bits of the timer index.

module tick_timer_bank_unit #(
    parameter int NUM_TIMERS = 16,
    parameter int TICK_BITS  = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [ttb_pkg::OPCODE_W-1:0]  opcode,
    input  logic [ttb_pkg::INDEX_W-1:0]   timer_index,
    input  logic [ttb_pkg::LOAD_W-1:0]    load_value,
    input  logic                          periodic,
    output logic                          result_valid,
    output logic [1:0]                    result_kind,
    output logic [ttb_pkg::INDEX_W-1:0]   result_index,
    output logic [1:0]                    error_code,
    output logic                          last
);
    import ttb_pkg::*;

    localparam int              POS_W    = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(NUM_TIMERS - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } state_t;

    state_t             state_reg, state_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               pend_valid_reg, pend_valid_next;
    logic [INDEX_W-1:0] pend_idx_reg, pend_idx_next;
    ttb_scan_t          scan_reg, scan_next;

    logic               rv_reg, rv_next;
    logic [1:0]         kind_reg, kind_next;
    logic [INDEX_W-1:0] ridx_reg, ridx_next;
    logic [1:0]         err_reg, err_next;
    logic               last_reg, last_next;

    ttb_cmd_t            cmd;
    logic [NUM_TIMERS:0] tok_chain;
    logic [NUM_TIMERS-1:0] hit_vec;
    logic [NUM_TIMERS-1:0] sel_vec;
    logic                any_hit;

    assign busy = (state_reg != ST_IDLE);

    // command seen by every cell; valid only on a transfer
    assign cmd.valid       = start && !busy;
    assign cmd.opcode      = opcode;
    assign cmd.timer_index = timer_index;
    assign cmd.load_value  = load_value;

    // token enters the first cell on the transfer of a tick or an assign
    assign tok_chain[0] = cmd.valid && ((opcode == OP_TICK) || (opcode == OP_ASSIGN));

    genvar g;
    generate
        for (g = 0; g < NUM_TIMERS; g++)
        begin : g_cell
            ttb_cell #(
                .INDEX     (g),
                .TICK_BITS (TICK_BITS)
            ) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .cmd     (cmd),
                .scan    (scan_reg),
                .tok_in  (tok_chain[g]),
                .tok_out (tok_chain[g+1]),
                .hit     (hit_vec[g]),
                .sel     (sel_vec[g])
            );
        end
    endgenerate

    // only the cell holding the token can hit, so the or names pos_reg
    assign any_hit = |hit_vec;

    always_comb
    begin
        state_next      = state_reg;
        pos_next        = pos_reg;
        cnt_next        = cnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        scan_next       = scan_reg;
        rv_next         = 1'b0;
        kind_next       = KIND_DONE;
        ridx_next       = '0;
        err_next        = ERR_NONE;
        last_next       = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    priority if (opcode == OP_TICK)
                    begin
                        state_next         = ST_SCAN;
                        pos_next           = '0;
                        cnt_next           = '0;
                        pend_valid_next    = 1'b0;
                        scan_next.assign_op = 1'b0;
                        scan_next.periodic  = 1'b0;
                    end
                    else if (opcode == OP_ASSIGN)
                    begin
                        state_next         = ST_SCAN;
                        pos_next           = '0;
                        scan_next.assign_op = 1'b1;
                        scan_next.periodic  = periodic;
                    end
                    else if ((opcode == OP_KICK) || (opcode == OP_STOP)
                             || (opcode == OP_KILL))
                    begin
                        rv_next   = 1'b1;
                        last_next = 1'b1;
                        if (!(|sel_vec))
                        begin
                            kind_next = KIND_ERROR;
                            err_next  = ERR_NOT_IN_USE;
                        end
                    end
                    else
                    begin
                        // opcode with no meaning: plain done
                        rv_next   = 1'b1;
                        last_next = 1'b1;
                    end
                end
            end

            ST_SCAN:
            begin
                if (scan_reg.assign_op)
                begin
                    if (any_hit)
                    begin
                        rv_next    = 1'b1;
                        kind_next  = KIND_ASSIGNED;
                        ridx_next  = INDEX_W'(pos_reg);
                        last_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else if (pos_reg == LAST_POS)
                    begin
                        rv_next    = 1'b1;
                        kind_next  = KIND_ERROR;
                        err_next   = ERR_NO_FREE;
                        last_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        pos_next = POS_W'(pos_reg + 1'b1);
                    end
                end
                else
                begin
                    if (any_hit && (cnt_reg < CNT_W'(MAX_RESULTS)))
                    begin
                        // release the held expiry, hold this one
                        if (pend_valid_reg)
                        begin
                            rv_next   = 1'b1;
                            kind_next = KIND_EXPIRED;
                            ridx_next = pend_idx_reg;
                        end
                        pend_valid_next = 1'b1;
                        pend_idx_next   = INDEX_W'(pos_reg);
                        cnt_next        = CNT_W'(cnt_reg + 1'b1);
                    end
                    if (pos_reg == LAST_POS)
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        pos_next = POS_W'(pos_reg + 1'b1);
                    end
                end
            end

            ST_FLUSH:
            begin
                rv_next   = 1'b1;
                last_next = 1'b1;
                if (pend_valid_reg)
                begin
                    kind_next = KIND_EXPIRED;
                    ridx_next = pend_idx_reg;
                end
                pend_valid_next = 1'b0;
                state_next      = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pos_reg        <= '0;
            cnt_reg        <= '0;
            pend_valid_reg <= 1'b0;
            scan_reg       <= '0;
            rv_reg         <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pos_reg        <= pos_next;
            cnt_reg        <= cnt_next;
            pend_valid_reg <= pend_valid_next;
            scan_reg       <= scan_next;
            rv_reg         <= rv_next;
        end
    end

    // result payload and held expiry index
    always_ff @(posedge clk)
    begin
        pend_idx_reg <= pend_idx_next;
        kind_reg     <= kind_next;
        ridx_reg     <= ridx_next;
        err_reg      <= err_next;
        last_reg     <= last_next;
    end

    assign result_valid = rv_reg;
    assign result_kind  = kind_reg;
    assign result_index = ridx_reg;
    assign error_code   = err_reg;
    assign last         = last_reg;

endmodule

`default_nettype wire

@@ rtl/ttb_checker.sv @@
// port-level checks for the tick timer bank, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module ttb_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic [2:0] opcode,
    input wire logic [3:0] timer_index,
    input wire logic [15:0] load_value,
    input wire logic       periodic,
    input wire logic       result_valid,
    input wire logic [1:0] result_kind,
    input wire logic [3:0] result_index,
    input wire logic [1:0] error_code,
    input wire logic       last
);
    import ttb_pkg::*;

    // a direct command gives its single result in the next cycle
    a_direct_result : assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && opcode != OP_TICK && opcode != OP_ASSIGN)
        |=> (result_valid && last && !busy))
        else $error("direct command did not give one final result");

    // tick and assign occupy the bank after their transfer
    a_scan_busy : assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (opcode == OP_TICK || opcode == OP_ASSIGN)) |=> busy)
        else $error("scan command did not raise busy");

    // error code only accompanies an error result
    a_err_kind : assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_kind != KIND_ERROR) |-> (error_code == ERR_NONE))
        else $error("error code on a non-error result");

    // done, assigned and error results always close their command
    a_single_last : assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_kind != KIND_EXPIRED) |-> last)
        else $error("non-expiry result without last");

endmodule

bind tick_timer_bank_unit ttb_checker u_ttb_checker (.*);

`default_nettype wire
